// ----- rtl/core/dmx_slots_to_led_pixels_core_defines.svh -----
// Assertion macros for the DMX slot to LED pixel core.
// Expects clk and arst_n in the scope of each use.
`ifndef DMX_SLOTS_TO_LED_PIXELS_CORE_DEFINES_SVH
`define DMX_SLOTS_TO_LED_PIXELS_CORE_DEFINES_SVH

// property checked every cycle outside reset
`define DSL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// antecedent this cycle implies consequent next cycle
`define DSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/dsl_pkg.sv -----
// Shared types, constants and helpers of the DMX slot to LED pixel core.
// No dependencies.
package dsl_pkg;

	localparam int MAX_SLOTS_DEF   = 512;
	localparam int MAX_PIXELS_DEF  = 680;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int IDX_W  = 10;
	localparam int CHAN_W = 8;

	// floor(x/3) = (x*683) >> 11 for x below 2048
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_MUL_W = 10;
	localparam int DIV3_SHIFT = 11;

	localparam logic [IDX_W-1:0] LED_COUNT_RST = 10'd170;
	localparam logic [IDX_W-1:0] START_ADDR_RST = 10'd1;
	localparam logic [IDX_W-1:0] IDX_MAX = 10'd1023;

	localparam logic [IDX_W-1:0] RGB_BEGIN_P1  = 10'd170;
	localparam logic [IDX_W-1:0] RGB_BEGIN_P2  = 10'd340;
	localparam logic [IDX_W-1:0] RGB_BEGIN_P3  = 10'd510;
	localparam logic [IDX_W-1:0] RGBW_BEGIN_P1 = 10'd128;
	localparam logic [IDX_W-1:0] RGBW_BEGIN_P2 = 10'd256;
	localparam logic [IDX_W-1:0] RGBW_BEGIN_P3 = 10'd384;

	localparam logic [1:0] PORT_0 = 2'd0;
	localparam logic [1:0] PORT_1 = 2'd1;
	localparam logic [1:0] PORT_2 = 2'd2;
	localparam logic [1:0] PORT_3 = 2'd3;

	localparam logic [1:0] PH_FIRST    = 2'd0;
	localparam logic [1:0] PH_LAST_RGB = 2'd2;
	localparam logic [1:0] PH_LAST_RGBW = 2'd3;

	localparam logic [1:0] REG_LED_COUNT  = 2'd0;
	localparam logic [1:0] REG_RGBW_MODE  = 2'd1;
	localparam logic [1:0] REG_START_ADDR = 2'd2;

	typedef struct packed {
		logic              write_led;
		logic [IDX_W-1:0]  led_index;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] white;
		logic              refresh;
	} pix_result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [IDX_W-1:0] port_begin(logic [1:0] port, logic rgbw);
		logic [IDX_W-1:0] b;
		case (port)
			PORT_1: b = rgbw ? RGBW_BEGIN_P1 : RGB_BEGIN_P1;
			PORT_2: b = rgbw ? RGBW_BEGIN_P2 : RGB_BEGIN_P2;
			PORT_3: b = rgbw ? RGBW_BEGIN_P3 : RGB_BEGIN_P3;
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/core/dsl_front.sv -----
// Front end: takes slot beats, tracks frame position and channel grouping,
// and builds pixel/refresh results. Depends on dsl_pkg.
module dsl_front #(
	parameter int MAX_SLOTS  = dsl_pkg::MAX_SLOTS_DEF,
	parameter int MAX_PIXELS = dsl_pkg::MAX_PIXELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 port_id,
	input  logic [7:0]                 slot_value,
	input  logic                       frame_end,
	input  logic [dsl_pkg::IDX_W-1:0]  led_count,
	input  logic                       rgbw_mode,
	input  logic [dsl_pkg::IDX_W-1:0]  start_address,
	input  dsl_pkg::q_status_t         q_stat,
	output logic                       push,
	output dsl_pkg::pix_result_t       push_data
);

	localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
	localparam int PROD_W = SLOT_W + dsl_pkg::DIV3_MUL_W;

	logic [SLOT_W-1:0]          slot_q;
	logic [1:0]                 phase_q;
	logic [dsl_pkg::IDX_W-1:0]  pix_q;
	logic [7:0]                 held_q [3];

	logic                       accept;
	logic                       port_ok;
	logic                       first;
	logic [dsl_pkg::IDX_W-1:0]  len;
	logic [dsl_pkg::IDX_W-1:0]  begin_idx;
	logic [dsl_pkg::IDX_W-1:0]  pix_cur;
	logic [1:0]                 ph_cur;
	logic [1:0]                 ph_eff;
	logic                       in_range;
	logic [dsl_pkg::IDX_W-1:0]  skip;
	logic                       take;
	logic                       complete;
	logic [SLOT_W-1:0]          pos_nx;
	logic [PROD_W-1:0]          prod;
	logic [dsl_pkg::IDX_W-1:0]  quot;
	logic                       wr;
	logic                       refresh;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign port_ok  = !port_id[2];

	always_comb begin
		len = (led_count < dsl_pkg::IDX_W'(MAX_PIXELS)) ? led_count
			: dsl_pkg::IDX_W'(MAX_PIXELS);
		first     = (slot_q == '0);
		begin_idx = dsl_pkg::port_begin(port_id[1:0], rgbw_mode);
		pix_cur   = first ? begin_idx : pix_q;
		ph_cur    = first ? dsl_pkg::PH_FIRST : phase_q;
		ph_eff    = (!rgbw_mode && ph_cur == dsl_pkg::PH_LAST_RGBW) ? dsl_pkg::PH_FIRST
			: ph_cur;
		in_range  = slot_q < SLOT_W'(MAX_SLOTS);
		if (port_id[1:0] == dsl_pkg::PORT_0
				&& len < dsl_pkg::port_begin(dsl_pkg::PORT_1, rgbw_mode)
				&& start_address != '0) begin
			skip = start_address - 1'b1;
		end else begin
			skip = '0;
		end
		take     = in_range && (dsl_pkg::IDX_W'(slot_q) >= skip);
		complete = take && (ph_eff == (rgbw_mode ? dsl_pkg::PH_LAST_RGBW
			: dsl_pkg::PH_LAST_RGB));
		pos_nx   = in_range ? slot_q + 1'b1 : slot_q;
		prod     = PROD_W'(pos_nx) * PROD_W'(dsl_pkg::DIV3_MUL);
		quot     = rgbw_mode ? dsl_pkg::IDX_W'(pos_nx >> 2)
			: dsl_pkg::IDX_W'(prod >> dsl_pkg::DIV3_SHIFT);
		refresh  = frame_end
			&& ({1'b0, begin_idx} + {1'b0, quot} >= {1'b0, len});
		wr       = complete && (pix_cur < len);

		push_data.write_led = wr;
		push_data.led_index = wr ? pix_cur : '0;
		push_data.red       = wr ? held_q[0] : '0;
		push_data.green     = wr ? held_q[1] : '0;
		push_data.blue      = wr ? (rgbw_mode ? held_q[2] : slot_value) : '0;
		push_data.white     = (wr && rgbw_mode) ? slot_value : '0;
		push_data.refresh   = refresh;
		push = accept && port_ok && (wr || refresh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			phase_q   <= dsl_pkg::PH_FIRST;
			pix_q     <= '0;
			held_q[0] <= '0;
			held_q[1] <= '0;
			held_q[2] <= '0;
		end else if (accept && port_ok) begin
			slot_q <= frame_end ? '0 : pos_nx;
			if (complete) begin
				pix_q <= (pix_cur != dsl_pkg::IDX_MAX) ? pix_cur + 1'b1 : pix_cur;
			end else begin
				pix_q <= pix_cur;
			end
			if (frame_end || complete) begin
				phase_q <= dsl_pkg::PH_FIRST;
			end else if (take) begin
				phase_q <= ph_eff + 1'b1;
			end else begin
				phase_q <= ph_cur;
			end
			if (take && !complete) begin
				case (ph_eff)
					2'd0: held_q[0] <= slot_value;
					2'd1: held_q[1] <= slot_value;
					2'd2: held_q[2] <= slot_value;
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- rtl/core/dsl_queue.sv -----
// Short result queue between front and back end.
// Depends on dsl_pkg and the core defines header.
`include "dmx_slots_to_led_pixels_core_defines.svh"

module dsl_queue #(
	parameter int DEPTH = dsl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dsl_pkg::pix_result_t  push_data,
	input  logic                  pop,
	output dsl_pkg::pix_result_t  pop_data,
	output dsl_pkg::q_status_t    q_stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	dsl_pkg::pix_result_t mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`DSL_ASSERT(a_no_overflow, !(push && q_stat.full), "push into full queue")
	`DSL_ASSERT(a_no_underflow, !(pop && q_stat.empty), "pop from empty queue")
	`DSL_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "count lost")

endmodule

// ----- rtl/core/dsl_back.sv -----
// Back end: drains the result queue into the registered output beat.
// Depends on dsl_pkg.
module dsl_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dsl_pkg::q_status_t    q_stat,
	input  dsl_pkg::pix_result_t  pop_data,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output dsl_pkg::pix_result_t  out_data
);

	logic                 valid_q;
	dsl_pkg::pix_result_t res_q;

	assign pop       = !q_stat.empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= pop || (valid_q && out_stall);
		end
	end

endmodule

// ----- rtl/core/dmx_slots_to_led_pixels_core.sv -----
// DMX slot to LED pixel mapper: top level with the APB register block.
// Depends on dsl_pkg, dsl_front, dsl_queue and dsl_back.
//
// One DMX slot beat is taken per clock while in_stall is low. The front end
// updates its frame counters and holds partial channel groups in the same
// cycle and pushes a result (pixel write, refresh or both) into a queue of
// QUEUE_DEPTH entries; the back end moves it from the queue into the output
// register. in_stall is high only while the queue is full, which happens
// only when out_stall holds back results. Beats that cause no result
// (skipped slots, partial groups, ports 4 to 7) are taken and dropped.
// Registers: led_count at 0x0, rgbw_mode at 0x4, start_address at 0x8;
// write them only while no beat is in flight.
module dmx_slots_to_led_pixels_core #(
	parameter int MAX_SLOTS   = dsl_pkg::MAX_SLOTS_DEF,
	parameter int MAX_PIXELS  = dsl_pkg::MAX_PIXELS_DEF,
	parameter int QUEUE_DEPTH = dsl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  port_id,
	input  logic [7:0]  slot_value,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_led,
	output logic [9:0]  led_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  white,
	output logic        refresh
);

	logic [dsl_pkg::IDX_W-1:0] led_count_q;
	logic                      rgbw_mode_q;
	logic [dsl_pkg::IDX_W-1:0] start_addr_q;
	logic                      cfg_wr;

	dsl_pkg::q_status_t   q_stat;
	dsl_pkg::pix_result_t push_data;
	dsl_pkg::pix_result_t pop_data;
	dsl_pkg::pix_result_t out_data;
	logic                 push;
	logic                 pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q  <= dsl_pkg::LED_COUNT_RST;
			rgbw_mode_q  <= 1'b0;
			start_addr_q <= dsl_pkg::START_ADDR_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				dsl_pkg::REG_LED_COUNT:  led_count_q  <= pwdata[9:0];
				dsl_pkg::REG_RGBW_MODE:  rgbw_mode_q  <= pwdata[0];
				dsl_pkg::REG_START_ADDR: start_addr_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			dsl_pkg::REG_LED_COUNT:  prdata = {22'd0, led_count_q};
			dsl_pkg::REG_RGBW_MODE:  prdata = {31'd0, rgbw_mode_q};
			dsl_pkg::REG_START_ADDR: prdata = {22'd0, start_addr_q};
			default:                 prdata = '0;
		endcase
	end

	dsl_front #(
		.MAX_SLOTS  (MAX_SLOTS),
		.MAX_PIXELS (MAX_PIXELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.port_id       (port_id),
		.slot_value    (slot_value),
		.frame_end     (frame_end),
		.led_count     (led_count_q),
		.rgbw_mode     (rgbw_mode_q),
		.start_address (start_addr_q),
		.q_stat        (q_stat),
		.push          (push),
		.push_data     (push_data)
	);

	dsl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	dsl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign write_led = out_data.write_led;
	assign led_index = out_data.led_index;
	assign red       = out_data.red;
	assign green     = out_data.green;
	assign blue      = out_data.blue;
	assign white     = out_data.white;
	assign refresh   = out_data.refresh;

endmodule

// ----- verif/tb_dmx_slots_to_led_pixels_core.sv -----
// Testbench for dmx_slots_to_led_pixels_core: directed and random slot traffic
// checked against an in-bench pixel mapping predictor, APB register access.
// Depends on dsl_pkg and the RTL of dmx_slots_to_led_pixels_core.
module tb_dmx_slots_to_led_pixels_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_LIMIT  = 512;
	localparam int PIXEL_LIMIT = 680;
	localparam int SETTLE_CYC  = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  port_id = '0;
	logic [7:0]  slot_value = '0;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        write_led;
	logic [9:0]  led_index;
	logic [7:0]  red, green, blue, white;
	logic        refresh;

	// register mirror
	logic [9:0] cfg_led_count = dsl_pkg::LED_COUNT_RST;
	logic       cfg_rgbw = 1'b0;
	logic [9:0] cfg_start_addr = dsl_pkg::START_ADDR_RST;

	// predictor state
	logic [9:0] frame_slot_pos = '0;
	logic [1:0] chan_phase = dsl_pkg::PH_FIRST;
	logic [9:0] next_pixel = '0;
	logic [7:0] held_chan [3] = '{8'd0, 8'd0, 8'd0};

	dsl_pkg::pix_result_t pix_expect [$];

	int errors = 0;
	int slots_sent = 0;
	int results_seen = 0;
	int writes_seen = 0;
	int refreshes_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	dmx_slots_to_led_pixels_core u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.port_id(port_id), .slot_value(slot_value), .frame_end(frame_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.write_led(write_led), .led_index(led_index),
		.red(red), .green(green), .blue(blue), .white(white),
		.refresh(refresh)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic int strip_begin(input logic [2:0] port);
		case (port)
			3'd1: return cfg_rgbw ? dsl_pkg::RGBW_BEGIN_P1 : dsl_pkg::RGB_BEGIN_P1;
			3'd2: return cfg_rgbw ? dsl_pkg::RGBW_BEGIN_P2 : dsl_pkg::RGB_BEGIN_P2;
			3'd3: return cfg_rgbw ? dsl_pkg::RGBW_BEGIN_P3 : dsl_pkg::RGB_BEGIN_P3;
			default: return 0;
		endcase
	endfunction

	task automatic map_slot(input logic [2:0] port, input logic [7:0] val, input logic last);
		dsl_pkg::pix_result_t res;
		int group, strip_len, pos, skip_n;
		logic [1:0] ph;
		res = '0;
		group = cfg_rgbw ? 4 : 3;
		strip_len = (cfg_led_count < PIXEL_LIMIT) ? cfg_led_count : PIXEL_LIMIT;
		if (port > 3'd3)
			return;
		if (frame_slot_pos == 0) begin
			next_pixel = 10'(strip_begin(port));
			chan_phase = dsl_pkg::PH_FIRST;
		end
		if (frame_slot_pos < SLOT_LIMIT) begin
			pos = frame_slot_pos;
			frame_slot_pos = frame_slot_pos + 1'b1;
			skip_n = 0;
			if (port == 3'd0 && strip_len < strip_begin(3'd1) && cfg_start_addr != 0)
				skip_n = cfg_start_addr - 1;
			if (pos >= skip_n) begin
				ph = chan_phase;
				if (!cfg_rgbw && ph == dsl_pkg::PH_LAST_RGBW)
					ph = dsl_pkg::PH_FIRST;
				if (int'(ph) + 1 == group) begin
					chan_phase = dsl_pkg::PH_FIRST;
					if (next_pixel < strip_len) begin
						res.write_led = 1'b1;
						res.led_index = next_pixel;
						res.red = held_chan[0];
						res.green = held_chan[1];
						if (cfg_rgbw) begin
							res.blue = held_chan[2];
							res.white = val;
						end else begin
							res.blue = val;
						end
					end
					if (next_pixel < dsl_pkg::IDX_MAX)
						next_pixel = next_pixel + 1'b1;
				end else begin
					held_chan[ph] = val;
					chan_phase = ph + 1'b1;
				end
			end
		end
		if (last) begin
			res.refresh = (strip_begin(port) + int'(frame_slot_pos) / group) >= strip_len;
			frame_slot_pos = '0;
			chan_phase = dsl_pkg::PH_FIRST;
		end
		if (res.write_led || res.refresh)
			pix_expect.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (act !== exp) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		dsl_pkg::pix_result_t exp;
		if (arst_n && out_valid && !out_stall) begin
			if (pix_expect.size() == 0) begin
				$error("unexpected result beat: write_led %0d led_index %0d refresh %0d",
					write_led, led_index, refresh);
				errors++;
			end else begin
				exp = pix_expect.pop_front();
				check_field("write_led", exp.write_led, write_led);
				check_field("led_index", exp.led_index, led_index);
				check_field("red", exp.red, red);
				check_field("green", exp.green, green);
				check_field("blue", exp.blue, blue);
				check_field("white", exp.white, white);
				check_field("refresh", exp.refresh, refresh);
				results_seen++;
				if (exp.write_led) writes_seen++;
				if (exp.refresh) refreshes_seen++;
			end
		end
	end

	task automatic push_slot(input logic [2:0] port, input logic [7:0] val, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		port_id <= port;
		slot_value <= val;
		frame_end <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		map_slot(port, val, last);
		if (port <= 3'd3)
			slots_sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pix_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] sel, input logic [9:0] val);
		logic [31:0] data;
		data = $urandom;
		data[9:0] = val;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (sel)
			dsl_pkg::REG_LED_COUNT: cfg_led_count = data[9:0];
			dsl_pkg::REG_RGBW_MODE: cfg_rgbw = data[0];
			dsl_pkg::REG_START_ADDR: cfg_start_addr = data[9:0];
			default: ;
		endcase
	endtask

	task automatic reg_check(input logic [1:0] sel, input string name, input logic [9:0] exp);
		logic [31:0] mask;
		mask = (sel == dsl_pkg::REG_RGBW_MODE) ? 32'h1 : 32'h3FF;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		check_field(name, exp & mask, prdata & mask);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic [9:0] leds, input logic rgbw, input logic [9:0] start);
		reg_write(dsl_pkg::REG_LED_COUNT, leds);
		reg_write(dsl_pkg::REG_RGBW_MODE, {9'd0, rgbw});
		reg_write(dsl_pkg::REG_START_ADDR, start);
	endtask

	task automatic pick_config;
		logic [9:0] leds, start;
		case ($urandom_range(7))
			0: leds = 10'd0;
			1: leds = 10'd1;
			2: leds = 10'($urandom_range(2, 169));
			3: leds = 10'($urandom_range(170, 171));
			4: leds = 10'd680;
			5: leds = 10'd1023;
			default: leds = 10'($urandom_range(0, 680));
		endcase
		case ($urandom_range(7))
			0: start = 10'd0;
			1: start = 10'd1;
			2: start = 10'd2;
			3: start = 10'd512;
			4: start = 10'd513;
			5: start = 10'd1023;
			default: start = 10'($urandom_range(1, 40));
		endcase
		set_config(leds, 1'($urandom_range(1)), start);
	endtask

	task automatic send_frame(input logic [2:0] port, input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0)
				push_slot(3'($urandom_range(4, 7)), 8'($urandom), 1'($urandom_range(1)));
			push_slot(port, 8'($urandom), i == len - 1);
		end
	endtask

	task automatic test_register_access;
		reg_check(dsl_pkg::REG_LED_COUNT, "led_count", dsl_pkg::LED_COUNT_RST);
		reg_check(dsl_pkg::REG_RGBW_MODE, "rgbw_mode", 10'd0);
		reg_check(dsl_pkg::REG_START_ADDR, "start_address", dsl_pkg::START_ADDR_RST);
		set_config(10'd1023, 1'b1, 10'd1023);
		reg_check(dsl_pkg::REG_LED_COUNT, "led_count", cfg_led_count);
		reg_check(dsl_pkg::REG_RGBW_MODE, "rgbw_mode", {9'd0, cfg_rgbw});
		reg_check(dsl_pkg::REG_START_ADDR, "start_address", cfg_start_addr);
		set_config(dsl_pkg::LED_COUNT_RST, 1'b0, dsl_pkg::START_ADDR_RST);
	endtask

	task automatic test_directed;
		// defaults: one whole rgb group, then an ignored port carrying frame_end
		push_slot(3'd0, 8'h00, 1'b0);
		push_slot(3'd0, 8'hFF, 1'b0);
		push_slot(3'd0, 8'hA5, 1'b1);
		push_slot(3'd7, 8'hFF, 1'b1);
		// port 3 begins past the strip: refresh only
		push_slot(3'd3, 8'h5A, 1'b0);
		push_slot(3'd3, 8'h3C, 1'b1);
		// partial group dropped at frame end, strip of one pixel
		drain;
		set_config(10'd1, 1'b0, 10'd1);
		push_slot(3'd0, 8'h11, 1'b0);
		push_slot(3'd0, 8'h22, 1'b0);
		push_slot(3'd0, 8'h33, 1'b0);
		push_slot(3'd0, 8'h44, 1'b1);
		// rgbw with start address zero, then skipped slots
		drain;
		set_config(10'd4, 1'b1, 10'd0);
		for (int i = 0; i < 4; i++)
			push_slot(3'd0, 8'(8'hF0 + i), i == 3);
		drain;
		reg_write(dsl_pkg::REG_START_ADDR, 10'd3);
		for (int i = 0; i < 6; i++)
			push_slot(3'd0, 8'(8'h80 + i), i == 5);
		// start address beyond the frame
		drain;
		reg_write(dsl_pkg::REG_START_ADDR, 10'd1023);
		for (int i = 0; i < 4; i++)
			push_slot(3'd0, 8'(8'hC0 + i), i == 3);
		drain;
	endtask

	task automatic test_mode_switch_mid_group;
		set_config(10'd680, 1'b1, 10'd1);
		for (int i = 0; i < 3; i++)
			push_slot(3'd1, 8'($urandom), 1'b0);
		drain;
		reg_write(dsl_pkg::REG_RGBW_MODE, 10'd0);
		for (int i = 0; i < 3; i++)
			push_slot(3'd1, 8'($urandom), i == 2);
		drain;
	endtask

	task automatic test_slot_overflow;
		set_config(10'd680, 1'b0, 10'd1);
		send_frame(3'd0, SLOT_LIMIT + 3);
		drain;
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_slots);
		int first, roll, len;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		first = slots_sent;
		drain;
		pick_config;
		while (slots_sent - first < n_slots) begin
			roll = $urandom_range(99);
			if (roll < 85) begin
				roll = $urandom_range(99);
				if (roll < 75) len = $urandom_range(1, 24);
				else if (roll < 97) len = $urandom_range(25, 120);
				else len = $urandom_range(SLOT_LIMIT - 12, SLOT_LIMIT + 3);
				send_frame(3'($urandom_range(3)), len);
			end else begin
				repeat ($urandom_range(1, 12))
					push_slot(3'($urandom_range(7)), 8'($urandom), $urandom_range(7) == 0);
			end
			if ($urandom_range(5) == 0) begin
				drain;
				pick_config;
			end
		end
		drain;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access;
		test_directed;
		test_mode_switch_mid_group;
		test_slot_overflow;
		test_random_traffic(24, 88, 330);
		test_random_traffic(88, 24, 330);
		test_random_traffic(0, 0, 330);
		recv_stall_pct = 0;
		drain;
		repeat (20) @(posedge clk);
		$display("covered %0d slot beats over rgb/rgbw settings and idle mixes", slots_sent);
		$display("checked %0d results: %0d pixel writes, %0d refreshes",
			results_seen, writes_seen, refreshes_seen);
		if (errors == 0 && pix_expect.size() == 0) begin
			$display("tb_dmx_slots_to_led_pixels_core passed");
		end else begin
			if (pix_expect.size() != 0)
				$error("%0d expected results never arrived", pix_expect.size());
			$display("tb_dmx_slots_to_led_pixels_core failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout waiting for traffic to complete");
		$display("tb_dmx_slots_to_led_pixels_core failed");
		$finish;
	end

endmodule
